[hw/rtl/ddo_pkg.sv]
// Shared types, constants and the arctangent table of the differential drive odometry block.
package ddo_pkg;

  localparam int unsigned CounterBits = 16;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicCntW  = 5;
  localparam int unsigned MulW        = 34;
  localparam int unsigned MulCntW     = $clog2(MulW);
  localparam logic signed [32:0] CordicK = 33'sd652032874;

  localparam logic [1:0] OpTick   = 2'd0;
  localparam logic [1:0] OpLoad   = 2'd1;
  localparam logic [1:0] OpResync = 2'd2;
  localparam logic [1:0] OpRsvd   = 2'd3;

  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegLeftG  = 2'd1;
  localparam logic [1:0] RegRightG = 2'd2;
  localparam logic [1:0] RegTurn   = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [15:0]        left_count;
    logic [15:0]        right_count;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_heading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
  } out_t;

  typedef struct packed {
    logic                  start;
    logic signed [MulW-1:0] a;
    logic signed [MulW-1:0] b;
  } mul_req_t;

  function automatic logic signed [31:0] atan_lut(input logic [CordicCntW-1:0] i);
    logic signed [31:0] v;
    unique case (i)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      5'd24: v = 32'sd41;
      5'd25: v = 32'sd20;
      5'd26: v = 32'sd10;
      5'd27: v = 32'sd5;
      5'd28: v = 32'sd3;
      5'd29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/ddo_smul.sv]
// Bit-serial signed multiplier, one multiplier bit per cycle.
module ddo_smul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ddo_pkg::mul_req_t          req_i,
  output logic                       done_o,
  output logic signed [2*ddo_pkg::MulW-1:0] prod_o
);

  localparam int unsigned W = ddo_pkg::MulW;

  logic signed [2*W-1:0] a_q, acc_q;
  logic [W-1:0]          b_q;
  logic [ddo_pkg::MulCntW-1:0] cnt_q;
  logic                  busy_q, done_q;
  logic                  last;

  assign last = (cnt_q == ddo_pkg::MulCntW'(W - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Sign bit of the multiplier carries negative weight.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= (2*W)'(req_i.a);
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= last ? acc_q - a_q : acc_q + a_q;
      end
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[hw/rtl/differential_drive_odometry.sv]
// Top level of the differential drive wheel odometry block.
// Each input beat carries an opcode: tick (encoder counts), load pose, resync baseline,
// or the reserved code, which changes nothing. Every beat returns one output beat with
// the pose after it. A primed tick keeps the input stalled until its result is in the
// output register: six products in a shared bit-serial multiplier, each a start, the
// 34 multiplier bits and a done, plus 16 CORDIC rotations of one step per cycle. Other
// opcodes and an unprimed tick go straight from idle to the done state. A stalled output
// beat holds the sequencer before it returns to idle. Configuration writes are always
// ready.
module differential_drive_odometry (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ddo_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ddo_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned W = ddo_pkg::MulW;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SMulAl  = 4'd1;
  localparam logic [3:0] SMulAr  = 4'd2;
  localparam logic [3:0] SMulD   = 4'd3;
  localparam logic [3:0] SCordic = 4'd4;
  localparam logic [3:0] SMulDx  = 4'd5;
  localparam logic [3:0] SMulDy  = 4'd6;
  localparam logic [3:0] SMulT   = 4'd7;
  localparam logic [3:0] SDone   = 4'd8;

  logic [3:0] state_q;
  logic       go_q, primed_q, out_valid_q;
  ddo_pkg::out_t out_q;

  logic [15:0] radius_q, turn_q;
  logic signed [15:0] lgain_q, rgain_q;
  logic [15:0] prev_l_q, prev_r_q;
  logic signed [31:0] pos_x_q, pos_y_q, head_q;

  logic signed [15:0] dl_q, dr_q;
  logic signed [31:0] al_q, ar_q, dist_q;
  logic signed [32:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic               neg_q;
  logic [ddo_pkg::CordicCntW-1:0] step_q;

  ddo_pkg::mul_req_t mreq;
  logic              mdone;
  logic signed [2*W-1:0] prod;

  logic accept, out_free;
  logic signed [32:0] sum_w, diff_w;
  logic signed [31:0] atan_w;
  logic signed [32:0] xs, ys;
  logic signed [32:0] cx_nx, cy_nx;
  logic fold;
  logic cordic_last;
  logic go_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != SIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign sum_w  = 33'(ar_q) + 33'(al_q);
  assign diff_w = 33'(ar_q) - 33'(al_q);
  assign atan_w = ddo_pkg::atan_lut(step_q);
  assign xs     = cx_q >>> step_q;
  assign ys     = cy_q >>> step_q;
  assign fold   = (head_q > 32'sh4000_0000) || (head_q < -32'sh4000_0000);

  // One rotation step; the direction follows the sign of the residual angle.
  assign cx_nx       = cz_q[31] ? cx_q + ys : cx_q - ys;
  assign cy_nx       = cz_q[31] ? cy_q - xs : cy_q + xs;
  assign cordic_last = (step_q == ddo_pkg::CordicCntW'(ddo_pkg::CordicSteps - 1));

  // Kick the multiplier on entry to every product phase.
  assign go_d = (state_q == SIdle && accept && in_data_i.opcode == ddo_pkg::OpTick &&
                 primed_q) ||
                (mdone && (state_q == SMulAl || state_q == SMulAr ||
                           state_q == SMulDx || state_q == SMulDy)) ||
                (state_q == SCordic && cordic_last);

  // Route operands of the shared multiplier by phase.
  always_comb begin
    mreq.start = go_q;
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (state_q)
      SMulAl: begin
        mreq.a = W'(dl_q);
        mreq.b = W'(lgain_q);
      end
      SMulAr: begin
        mreq.a = W'(dr_q);
        mreq.b = W'(rgain_q);
      end
      SMulD: begin
        mreq.a = W'({1'b0, radius_q});
        mreq.b = W'(sum_w);
      end
      SMulDx: begin
        mreq.a = W'(dist_q);
        mreq.b = W'(cx_q);
      end
      SMulDy: begin
        mreq.a = W'(dist_q);
        mreq.b = W'(cy_q);
      end
      SMulT: begin
        mreq.a = W'({1'b0, turn_q});
        mreq.b = W'(diff_w);
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  ddo_smul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .done_o (mdone),
    .prod_o (prod)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      lgain_q  <= 16'sd16384;
      rgain_q  <= 16'sd16384;
      turn_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ddo_pkg::RegRadius: radius_q <= cfg_data_i;
        ddo_pkg::RegLeftG:  lgain_q  <= cfg_data_i;
        ddo_pkg::RegRightG: rgain_q  <= cfg_data_i;
        ddo_pkg::RegTurn:   turn_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and pose state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      go_q        <= 1'b0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      step_q      <= '0;
    end else begin
      go_q <= go_d;
      if (state_q == SDone && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (accept) begin
            state_q <= (in_data_i.opcode == ddo_pkg::OpTick && primed_q) ? SMulAl : SDone;
            unique case (in_data_i.opcode)
              ddo_pkg::OpTick: begin
                prev_l_q <= in_data_i.left_count;
                prev_r_q <= in_data_i.right_count;
                dl_q     <= in_data_i.left_count - prev_l_q;
                dr_q     <= in_data_i.right_count - prev_r_q;
                primed_q <= 1'b1;
              end
              ddo_pkg::OpLoad: begin
                pos_x_q <= in_data_i.new_x;
                pos_y_q <= in_data_i.new_y;
                head_q  <= in_data_i.new_heading;
              end
              ddo_pkg::OpResync: primed_q <= 1'b0;
              default: ;
            endcase
          end
        end
        SMulAl: if (mdone) begin
          al_q    <= prod[31:0];
          state_q <= SMulAr;
        end
        SMulAr: if (mdone) begin
          ar_q    <= prod[31:0];
          state_q <= SMulD;
        end
        SMulD: if (mdone) begin
          // Saturate the Q16.16 travel; fold the heading into the CORDIC range.
          if (prod[2*W-1:46] == {(2*W-46){prod[46]}}) begin
            dist_q <= prod[46:15];
          end else begin
            dist_q <= prod[2*W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end
          cx_q    <= ddo_pkg::CordicK;
          cy_q    <= '0;
          cz_q    <= fold ? head_q + 32'sh8000_0000 : head_q;
          neg_q   <= fold;
          step_q  <= '0;
          state_q <= SCordic;
        end
        SCordic: begin
          // Apply the fold sign on the last rotation.
          cx_q   <= (cordic_last && neg_q) ? -cx_nx : cx_nx;
          cy_q   <= (cordic_last && neg_q) ? -cy_nx : cy_nx;
          cz_q   <= cz_q[31] ? cz_q + atan_w : cz_q - atan_w;
          step_q <= step_q + 1'b1;
          if (cordic_last) begin
            state_q <= SMulDx;
          end
        end
        SMulDx: if (mdone) begin
          pos_x_q <= pos_x_q + prod[61:30];
          state_q <= SMulDy;
        end
        SMulDy: if (mdone) begin
          pos_y_q <= pos_y_q + prod[61:30];
          state_q <= SMulT;
        end
        SMulT: if (mdone) begin
          head_q  <= head_q + {prod[26:0], 5'b0};
          state_q <= SDone;
        end
        SDone: if (out_free) begin
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SDone && out_free) begin
      out_q.pose_x       <= pos_x_q;
      out_q.pose_y       <= pos_y_q;
      out_q.pose_heading <= head_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o) else $error("input taken while idle flag stays");
  a_mul_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdone |-> (state_q != SIdle && state_q != SDone && state_q != SCordic))
    else $error("multiplier finished outside a product phase");
  a_cordic_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SCordic) |-> (step_q < ddo_pkg::CordicCntW'(ddo_pkg::CordicSteps)))
    else $error("rotation counter overran");

endmodule

[bench/tb_differential_drive_odometry.sv]
// Self-checking testbench for the differential drive wheel odometry block.
`timescale 1ns / 100ps

module tb_differential_drive_odometry;

  localparam int unsigned WatchLimit = 40000;   // cycles with no handshake at all
  localparam int unsigned HoldCycles = 3000;    // long receiver hold-off
  localparam int unsigned SettleCycles = 300;   // about one primed tick

  // CORDIC arctangent steps, Q2.30 fractions of a right angle scaled to 2^30 = pi/2
  localparam longint AngleStep[16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861
  };
  localparam longint GainK = 652032874;

  logic clk, rst_n;
  logic in_valid, in_stall;
  ddo_pkg::in_t  in_data;
  logic out_valid, out_stall;
  ddo_pkg::out_t out_data;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  differential_drive_odometry u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Shadow of the block: configuration and pose state
  logic [15:0]        sh_radius, sh_turn;
  logic signed [15:0] sh_lgain, sh_rgain;
  logic [31:0]        sh_x, sh_y, sh_heading;
  logic [15:0]        sh_prev_l, sh_prev_r;
  logic               sh_primed;

  ddo_pkg::out_t pose_q[$];
  int   err_cnt;
  int   n_tick, n_load, n_resync, n_ignored, n_checked;
  logic no_idle;       // disables random gaps on both sides
  logic hold_req;      // asks the receiver for one long hold-off
  logic [15:0] enc_l, enc_r;   // running encoder readings for well-formed ticks
  int   beat_seen;     // not used; the watchdog keeps its own handshake flag

  // Rotate the unit vector by the heading: returns cos and sin in Q1.30
  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    longint z, x, y, nx;
    logic   flip;
    z    = longint'($signed(ang));
    x    = GainK;
    y    = 0;
    flip = 1'b0;
    // fold the back half-plane onto the front one
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      z    = longint'($signed(ang + 32'h8000_0000));
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - AngleStep[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + AngleStep[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Advance the shadow pose by one accepted beat and return the pose after it
  function automatic ddo_pkg::out_t advance_pose(input ddo_pkg::in_t b);
    ddo_pkg::out_t r;
    logic signed [15:0] dl, dr;
    longint al, ar, travel, c, s, dx, dy, t;
    case (b.opcode)
      ddo_pkg::OpTick: begin
        if (sh_primed) begin
          dl     = b.left_count - sh_prev_l;
          dr     = b.right_count - sh_prev_r;
          al     = longint'(dl) * longint'(sh_lgain);
          ar     = longint'(dr) * longint'(sh_rgain);
          travel = (longint'(sh_radius) * (ar + al)) >>> 15;
          if (travel > 64'sd2147483647) travel = 64'sd2147483647;
          if (travel < -64'sd2147483648) travel = -64'sd2147483648;
          rotate_unit(sh_heading, c, s);
          dx = (travel * c) >>> 30;
          dy = (travel * s) >>> 30;
          sh_x = sh_x + dx[31:0];
          sh_y = sh_y + dy[31:0];
          // heading uses the old value above, update it last
          t = (longint'(sh_turn) * (ar - al)) <<< 5;
          sh_heading = sh_heading + t[31:0];
        end
        sh_primed = 1'b1;
        sh_prev_l = b.left_count;
        sh_prev_r = b.right_count;
      end
      ddo_pkg::OpLoad: begin
        sh_x       = b.new_x;
        sh_y       = b.new_y;
        sh_heading = b.new_heading;
      end
      ddo_pkg::OpResync: sh_primed = 1'b0;
      default: ;
    endcase
    r.pose_x       = sh_x;
    r.pose_y       = sh_y;
    r.pose_heading = sh_heading;
    return r;
  endfunction

  // Offer one beat, with an occasional random gap first; predict on acceptance
  task automatic send_beat(input ddo_pkg::in_t b);
    logic took;
    if (!no_idle && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    pose_q.push_back(advance_pose(b));
    case (b.opcode)
      ddo_pkg::OpTick:   n_tick++;
      ddo_pkg::OpLoad:   n_load++;
      ddo_pkg::OpResync: n_resync++;
      default:           n_ignored++;
    endcase
  endtask

  // Drop valid, hold until every expected pose has come back, then let the block settle
  task automatic drain;
    in_valid <= 1'b0;
    wait (pose_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    logic took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    case (idx)
      ddo_pkg::RegRadius: sh_radius = val;
      ddo_pkg::RegLeftG:  sh_lgain  = val;
      ddo_pkg::RegRightG: sh_rgain  = val;
      default:            sh_turn   = val;
    endcase
  endtask

  task automatic set_all(input logic [15:0] rad, input logic [15:0] lg,
                         input logic [15:0] rg, input logic [15:0] tf);
    drain();
    write_reg(ddo_pkg::RegRadius, rad);
    write_reg(ddo_pkg::RegLeftG, lg);
    write_reg(ddo_pkg::RegRightG, rg);
    write_reg(ddo_pkg::RegTurn, tf);
    cfg_valid <= 1'b0;
  endtask

  function automatic ddo_pkg::in_t make_beat(input logic [1:0] op, input logic [15:0] l,
                                             input logic [15:0] r, input logic [31:0] x,
                                             input logic [31:0] y, input logic [31:0] h);
    ddo_pkg::in_t b;
    b.opcode      = op;
    b.left_count  = l;
    b.right_count = r;
    b.new_x       = x;
    b.new_y       = y;
    b.new_heading = h;
    return b;
  endfunction

  // Mostly well-formed ticks with modest wheel travel; some loads, resyncs and noise
  function automatic ddo_pkg::in_t random_beat();
    ddo_pkg::in_t b;
    int  pick;
    b    = make_beat(ddo_pkg::OpTick, 16'($urandom), 16'($urandom), $urandom, $urandom,
                     $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      enc_l = enc_l + 16'($signed($urandom_range(0, 400)) - 200);
      enc_r = enc_r + 16'($signed($urandom_range(0, 400)) - 200);
      b.left_count  = enc_l;
      b.right_count = enc_r;
    end else if (pick < 80) begin
      enc_l = b.left_count;     // full-range jump
      enc_r = b.right_count;
    end else if (pick < 88) begin
      b.opcode = ddo_pkg::OpLoad;
    end else if (pick < 95) begin
      b.opcode = ddo_pkg::OpResync;
    end else begin
      b.opcode = ddo_pkg::OpRsvd;   // reserved opcode, ignored by the block
    end
    return b;
  endfunction

  task automatic test_directed;
    set_all(16'hFFFF, 16'h4000, 16'h4000, 16'h1000);
    send_beat(make_beat(ddo_pkg::OpTick, 16'd0, 16'd0, '0, '0, '0));   // unprimed capture
    send_beat(make_beat(ddo_pkg::OpTick, 16'd100, 16'd200, '0, '0, '0));
    send_beat(make_beat(ddo_pkg::OpTick, 16'hFFFF, 16'hFFFF, '0, '0, '0));  // backward wrap
    send_beat(make_beat(ddo_pkg::OpTick, 16'h7FFF, 16'h7FFF, '0, '0, '0));  // half range
    send_beat(make_beat(ddo_pkg::OpTick, 16'hFFFF, 16'h0000, '0, '0, '0));
    send_beat(make_beat(ddo_pkg::OpLoad, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h8000_0000));
    send_beat(make_beat(ddo_pkg::OpTick, 16'h0100, 16'h0080, '0, '0, '0));
    send_beat(make_beat(ddo_pkg::OpLoad, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h4000_0000));
    send_beat(make_beat(ddo_pkg::OpTick, 16'h0200, 16'h0200, '0, '0, '0));
    send_beat(make_beat(ddo_pkg::OpLoad, '0, '0, '0, '0, 32'h4000_0001));  // past right angle
    send_beat(make_beat(ddo_pkg::OpTick, 16'h0300, 16'h0300, '0, '0, '0));
    send_beat(make_beat(ddo_pkg::OpLoad, '0, '0, '0, '0, 32'hC000_0000));
    send_beat(make_beat(ddo_pkg::OpTick, 16'h0400, 16'h0400, '0, '0, '0));
    send_beat(make_beat(ddo_pkg::OpLoad, '0, '0, '0, '0, 32'hBFFF_FFFF));
    send_beat(make_beat(ddo_pkg::OpTick, 16'h0500, 16'h0500, '0, '0, '0));
    send_beat(make_beat(ddo_pkg::OpResync, '1, '1, '1, '1, '1));        // drop baseline
    send_beat(make_beat(ddo_pkg::OpTick, 16'h8000, 16'h1234, '0, '0, '0));  // capture only
    send_beat(make_beat(ddo_pkg::OpTick, 16'h0000, 16'h9234, '0, '0, '0));
    send_beat(make_beat(ddo_pkg::OpRsvd, '1, '1, '1, '1, '1));          // ignored
    send_beat(make_beat(ddo_pkg::OpTick, 16'h0010, 16'h9244, '0, '0, '0));
    enc_l = 16'h0010;
    enc_r = 16'h9244;
  endtask

  task automatic test_setting_extremes;
    logic [15:0] lo_hi[4][4];
    lo_hi[0] = '{16'h0000, 16'h8000, 16'h8000, 16'h0000};
    lo_hi[1] = '{16'hFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF};
    lo_hi[2] = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF};
    lo_hi[3] = '{16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001};
    for (int k = 0; k < 4; k++) begin
      set_all(lo_hi[k][0], lo_hi[k][1], lo_hi[k][2], lo_hi[k][3]);
      repeat (60) send_beat(random_beat());
    end
  endtask

  task automatic test_random_phases;
    for (int p = 0; p < 7; p++) begin
      set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      no_idle = (p == 2);        // one stretch with no gaps on either side
      repeat (225) send_beat(random_beat());
      no_idle = 1'b0;
      drain();                   // sender pauses until all poses are back
    end
  endtask

  // Receiver holds off while beats keep coming, so the block backs up
  task automatic test_backpressure;
    set_all(16'h2000, 16'h4000, 16'hC000, 16'h0800);
    hold_req = 1'b1;
    repeat (20) send_beat(random_beat());
    hold_req = 1'b0;
    drain();
  endtask

  // Receiver stall: random gaps, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_req);
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 16);
      end
    end
  end

  // Compare each accepted pose with the oldest prediction
  initial begin
    logic v, s;
    ddo_pkg::out_t d, e;
    forever begin
      @(negedge clk);
      v = out_valid;
      s = out_stall;
      d = out_data;
      @(posedge clk);
      if (rst_n && v && !s) begin
        if (pose_q.size() == 0) begin
          $error("pose beat with nothing expected: x %h y %h heading %h",
                 d.pose_x, d.pose_y, d.pose_heading);
          err_cnt++;
        end else begin
          e = pose_q.pop_front();
          n_checked++;
          if (d.pose_x !== e.pose_x) begin
            $error("pose_x expected %h actual %h", e.pose_x, d.pose_x);
            err_cnt++;
          end
          if (d.pose_y !== e.pose_y) begin
            $error("pose_y expected %h actual %h", e.pose_y, d.pose_y);
            err_cnt++;
          end
          if (d.pose_heading !== e.pose_heading) begin
            $error("pose_heading expected %h actual %h", e.pose_heading, d.pose_heading);
            err_cnt++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which no channel moves a beat
  initial begin
    int quiet;
    logic any;
    quiet = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      any = (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready);
      @(posedge clk);
      quiet = any ? 0 : quiet + 1;
      if (quiet >= WatchLimit) begin
        $display("Timeout with %0d poses outstanding", pose_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    err_cnt   = 0;
    n_tick = 0; n_load = 0; n_resync = 0; n_ignored = 0; n_checked = 0;
    enc_l = '0; enc_r = '0;
    // reset state of the block
    sh_radius = '0; sh_lgain = 16'sd16384; sh_rgain = 16'sd16384; sh_turn = '0;
    sh_x = '0; sh_y = '0; sh_heading = '0;
    sh_prev_l = '0; sh_prev_r = '0; sh_primed = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_setting_extremes();
    test_backpressure();
    test_random_phases();

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (pose_q.size() != 0) begin
      $error("%0d poses never arrived", pose_q.size());
      err_cnt++;
    end
    $display("Covered %0d ticks, %0d pose loads, %0d resyncs, %0d ignored beats;",
             n_tick, n_load, n_resync, n_ignored);
    $display("%0d poses compared across extreme and random gain/radius settings.",
             n_checked);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
